[hdl/matrix_register_file_engine_assert.svh]
// assertion macro for the matrix register file engine checker
// no dependencies; included by the checker file only
`ifndef MATRIX_REGISTER_FILE_ENGINE_ASSERT_SVH
`define MATRIX_REGISTER_FILE_ENGINE_ASSERT_SVH

// implication checked on every rising edge outside reset
`define MRF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[hdl/mrf_pkg.sv]
// shared constants, types and op codes of the matrix register file engine
// used by the engine top, the alu, the checker and the bench; not by the memory
`timescale 1ns / 1ps

package mrf_pkg;
	localparam int DIM      = 16;
	localparam int NUM_REGS = 32;
	localparam int IW       = $clog2(DIM);
	localparam int RW       = $clog2(NUM_REGS);
	localparam int AW       = RW + 2 * IW;
	localparam int CW       = IW + 1;
	localparam int DW       = 32;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 40;

	localparam logic [3:0] OP_LOAD      = 4'd0;
	localparam logic [3:0] OP_READ      = 4'd1;
	localparam logic [3:0] OP_COLSCALE  = 4'd2;
	localparam logic [3:0] OP_ROWSUM    = 4'd3;
	localparam logic [3:0] OP_ADD       = 4'd4;
	localparam logic [3:0] OP_EMUL      = 4'd5;
	localparam logic [3:0] OP_RELU      = 4'd6;
	localparam logic [3:0] OP_TRANSPOSE = 4'd7;
	localparam logic [3:0] OP_TCOPY     = 4'd8;

	typedef logic signed [DW-1:0] word_t;

	typedef enum logic [1:0] {FN_PASS, FN_ADD, FN_MUL, FN_RELU} alu_fn_t;

	typedef struct packed {
		logic    en;
		alu_fn_t fn;
	} alu_ctrl_t;
endpackage

[hdl/matrix_register_file_engine.sv]
// matrix register file engine: 32 registers of 16x16 signed q16.16 words.
// channels: s_* carries one instruction per beat, m_* one result per beat.
// every instruction gives exactly one result beat (read_value, op_echo).
// steps, from the accepting edge to the result showing on m_*:
//   load, unknown op, rejected op: straight to the result
//   read: the addressed element only
//   add, emul, relu: every element of the matrix
//   colscale, rowsum: every element in use
//   transpose: each swapped pair above the diagonal, with two writes
//   transpose copy: full copy then transpose
// each element runs read, operate, write back through the one memory and
// the one shared multiply/add unit, which sets the per element cost.
// s_tready is high only while the sequencer is idle; the result waits in
// an output register, so a new instruction is taken while m_* is stalled,
// and the sequencer holds at its end until the output register is free.
// reset clears the sequencer and the output valid; matrix contents are
// undefined until written and are not cleared.
`timescale 1ns / 1ps

module matrix_register_file_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// op[3:0] reg_a[8:4] reg_b[13:9] reg_dest[18:14] row[22:19] col[26:23]
	// row_count[31:27] col_count[36:32] value[68:37] zero[71:69]
	input  logic [mrf_pkg::IN_W-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// read_value[31:0] op_echo[35:32] zero[39:36]
	output logic [mrf_pkg::OUT_W-1:0] m_tdata
);
	import mrf_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_EX, S_WB, S_WB2, S_FIN} state_t;

	state_t          state_q;
	logic [3:0]      op_q;
	logic [4:0]      ra_q, rb_q, rd_q;
	logic [3:0]      row_q, col_q;
	logic            czero_q, tphase_q;
	logic [IW-1:0]   o_q, i_q;
	logic [CW-1:0]   olim_q, ilim_q;
	word_t           acc_q, rv_q;
	logic            out_v_q;
	logic [OUT_W-1:0] out_d_q;

	logic [3:0]  in_op, in_row, in_col;
	logic [4:0]  in_ra, in_rb, in_rd, in_rcnt, in_ccnt;
	word_t       in_value;
	logic        accept, ok_a, ok_b, ok_d, ok_idx;
	logic [CW-1:0] rcl, ccl;
	state_t        start_st;
	logic [CW-1:0] olim_n, ilim_n;

	assign in_op    = s_tdata[3:0];
	assign in_ra    = s_tdata[8:4];
	assign in_rb    = s_tdata[13:9];
	assign in_rd    = s_tdata[18:14];
	assign in_row   = s_tdata[22:19];
	assign in_col   = s_tdata[26:23];
	assign in_rcnt  = s_tdata[31:27];
	assign in_ccnt  = s_tdata[36:32];
	assign in_value = s_tdata[68:37];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign ok_a     = int'(in_ra) < NUM_REGS;
	assign ok_b     = int'(in_rb) < NUM_REGS;
	assign ok_d     = int'(in_rd) < NUM_REGS;
	assign ok_idx   = (int'(in_row) < DIM) && (int'(in_col) < DIM);
	assign rcl      = (int'(in_rcnt) > DIM) ? CW'(DIM) : CW'(in_rcnt);
	assign ccl      = (int'(in_ccnt) > DIM) ? CW'(DIM) : CW'(in_ccnt);

	// start state and loop limits of the incoming instruction
	always_comb begin
		start_st = S_FIN;
		olim_n   = CW'(DIM);
		ilim_n   = CW'(DIM);
		unique case (in_op)
			OP_READ: begin
				olim_n = CW'(1);
				ilim_n = CW'(1);
				if (ok_a && ok_idx) start_st = S_RD;
			end
			OP_COLSCALE: begin
				olim_n = ccl;
				ilim_n = rcl;
				if (ok_a && ok_b && ok_d && (rcl != '0) && (ccl != '0))
					start_st = S_RD;
			end
			OP_ROWSUM: begin
				olim_n = rcl;
				ilim_n = (ccl == '0) ? CW'(1) : ccl;
				if (ok_a && ok_d && (rcl != '0)) start_st = S_RD;
			end
			OP_ADD, OP_EMUL: begin
				if (ok_a && ok_b && ok_d) start_st = S_RD;
			end
			OP_RELU, OP_TCOPY: begin
				if (ok_a && ok_d) start_st = S_RD;
			end
			OP_TRANSPOSE: begin
				if (ok_a) start_st = S_RD;
			end
			default: start_st = S_FIN;
		endcase
	end

	// memory and alu hookup
	logic          we;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	logic [DW-1:0] wdata, rdata_a, rdata_b;
	alu_ctrl_t     alu_ctrl;
	word_t         alu_x, alu_y, alu_res;

	mrf_ram #(.AW(AW), .DW(DW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(raddr_a), .raddr_b(raddr_b),
		.rdata_a(rdata_a), .rdata_b(rdata_b)
	);

	mrf_alu u_alu (.clk(clk), .ctrl(alu_ctrl), .x(alu_x), .y(alu_y), .result(alu_res));

	logic          xp, inner_last, outer_last;
	logic [RW-1:0] tgt;

	assign xp  = (op_q == OP_TRANSPOSE) || ((op_q == OP_TCOPY) && tphase_q);
	assign tgt = (op_q == OP_TRANSPOSE) ? ra_q[RW-1:0] : rd_q[RW-1:0];
	assign inner_last = ({1'b0, i_q} == ilim_q - CW'(1));
	assign outer_last = ({1'b0, o_q} == olim_q - CW'(1));

	always_comb begin
		raddr_a = {ra_q[RW-1:0], o_q, i_q};
		raddr_b = {rb_q[RW-1:0], o_q, i_q};
		if (xp) begin
			raddr_a = {tgt, i_q, o_q};
			raddr_b = {tgt, o_q, i_q};
		end else if (op_q == OP_COLSCALE) begin
			raddr_a = {ra_q[RW-1:0], i_q, o_q};
			raddr_b = {rb_q[RW-1:0], IW'(0), o_q};
		end else if (op_q == OP_READ) begin
			raddr_a = {ra_q[RW-1:0], row_q[IW-1:0], col_q[IW-1:0]};
		end
	end

	always_comb begin
		alu_ctrl.en = (state_q == S_EX);
		alu_x       = rdata_a;
		alu_y       = rdata_b;
		unique case (op_q)
			OP_COLSCALE, OP_EMUL: alu_ctrl.fn = FN_MUL;
			OP_ADD:               alu_ctrl.fn = FN_ADD;
			OP_RELU:              alu_ctrl.fn = FN_RELU;
			OP_ROWSUM: begin
				alu_ctrl.fn = FN_ADD;
				alu_x = (i_q == '0) ? '0 : acc_q;
				// an aliased source cell at column 0 reads as zero, as if the destination were cleared first
				alu_y = (czero_q || ((ra_q == rd_q) && (i_q == '0))) ? '0 : rdata_a;
			end
			default:              alu_ctrl.fn = FN_PASS;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = {rd_q[RW-1:0], o_q, i_q};
		wdata = alu_res;
		if (accept && (in_op == OP_LOAD) && ok_a && ok_idx) begin
			we    = 1'b1;
			waddr = {in_ra[RW-1:0], in_row[IW-1:0], in_col[IW-1:0]};
			wdata = in_value;
		end else if (state_q == S_WB) begin
			if (xp) begin
				we    = 1'b1;
				waddr = {tgt, i_q, o_q};
				wdata = rdata_b;
			end else if (op_q == OP_COLSCALE) begin
				we    = 1'b1;
				waddr = {rd_q[RW-1:0], i_q, o_q};
			end else if (op_q == OP_ROWSUM) begin
				we    = inner_last;
				waddr = {rd_q[RW-1:0], o_q, IW'(0)};
			end else begin
				we    = (op_q != OP_READ);
			end
		end else if (state_q == S_WB2) begin
			we    = 1'b1;
			waddr = {tgt, o_q, i_q};
			wdata = rdata_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			out_v_q  <= 1'b0;
			tphase_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready && (state_q != S_FIN)) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= in_op;
						ra_q     <= in_ra;
						rb_q     <= in_rb;
						rd_q     <= in_rd;
						row_q    <= in_row;
						col_q    <= in_col;
						czero_q  <= (ccl == '0);
						rv_q     <= '0;
						o_q      <= '0;
						i_q      <= (in_op == OP_TRANSPOSE) ? IW'(1) : '0;
						tphase_q <= (in_op == OP_TRANSPOSE);
						olim_q   <= olim_n;
						ilim_q   <= ilim_n;
						state_q  <= start_st;
					end
				end
				S_RD: state_q <= S_EX;
				S_EX: state_q <= S_WB;
				S_WB: begin
					if (op_q == OP_ROWSUM) acc_q <= alu_res;
					if (op_q == OP_READ) rv_q <= alu_res;
					if (xp) begin
						state_q <= S_WB2;
					end else if (inner_last) begin
						if (outer_last) begin
							if ((op_q == OP_TCOPY) && !tphase_q) begin
								tphase_q <= 1'b1;
								o_q      <= '0;
								i_q      <= IW'(1);
								state_q  <= S_RD;
							end else begin
								i_q     <= '0;
								state_q <= S_FIN;
							end
						end else begin
							i_q     <= '0;
							o_q     <= o_q + IW'(1);
							state_q <= S_RD;
						end
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_RD;
					end
				end
				S_WB2: begin
					// walk the upper triangle, pair (o,i) with i above o
					if (i_q == IW'(DIM - 1)) begin
						if (o_q == IW'(DIM - 2)) begin
							state_q <= S_FIN;
						end else begin
							o_q     <= o_q + IW'(1);
							i_q     <= o_q + IW'(2);
							state_q <= S_RD;
						end
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						out_d_q <= {4'b0, op_q, rv_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
endmodule

[hdl/mrf_ram.sv]
// generic single write, dual read memory with registered read data
// no package dependency
`timescale 1ns / 1ps

module mrf_ram #(
	parameter int AW = 13,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

[hdl/mrf_alu.sv]
// shared arithmetic unit: one multiplier and one adder, registered, then
// q16.16 rescale and saturation; depends on mrf_pkg
`timescale 1ns / 1ps

module mrf_alu (
	input  logic               clk,
	input  mrf_pkg::alu_ctrl_t ctrl,
	input  mrf_pkg::word_t     x,
	input  mrf_pkg::word_t     y,
	output mrf_pkg::word_t     result
);
	import mrf_pkg::*;

	logic signed [2*DW-1:0] prod_q;
	logic signed [DW:0]     sum_q;
	word_t                  x_q;
	alu_fn_t                fn_q;
	logic signed [2*DW-1:0] shifted;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_q <= (2*DW)'(x) * (2*DW)'(y);
			sum_q  <= {x[DW-1], x} + {y[DW-1], y};
			x_q    <= x;
			fn_q   <= ctrl.fn;
		end
	end

	// arithmetic shift is the floor of the division by 2^16
	assign shifted = prod_q >>> 16;

	always_comb begin
		unique case (fn_q)
			FN_MUL: begin
				if (shifted > (2*DW)'(32'sh7fffffff))
					result = 32'sh7fffffff;
				else if (shifted < -(2*DW)'(64'sh80000000))
					result = 32'sh80000000;
				else
					result = shifted[DW-1:0];
			end
			FN_ADD: begin
				if (sum_q[DW] != sum_q[DW-1])
					result = sum_q[DW] ? 32'sh80000000 : 32'sh7fffffff;
				else
					result = sum_q[DW-1:0];
			end
			FN_RELU: result = x_q[DW-1] ? '0 : x_q;
			FN_PASS: result = x_q;
		endcase
	end
endmodule

[hdl/mrf_chk.sv]
// port level checker for the matrix register file engine, bound to the top
// depends on mrf_pkg and matrix_register_file_engine_assert.svh
`timescale 1ns / 1ps
`include "matrix_register_file_engine_assert.svh"

module mrf_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [mrf_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [mrf_pkg::OUT_W-1:0] m_tdata
);
	import mrf_pkg::*;

	`MRF_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")
	`MRF_ASSERT(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")
	`MRF_ASSERT(a_busy, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "instruction taken while busy")
	`MRF_ASSERT(a_rv_zero, clk, arst_n, m_tvalid && (m_tdata[35:32] != OP_READ) |-> (m_tdata[31:0] == 32'd0) && (m_tdata[39:36] == 4'd0), "nonzero value on non-read result")
endmodule

bind matrix_register_file_engine mrf_chk u_mrf_chk (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[bench/matrix_register_file_engine_tb.sv]
// self-checking bench for the matrix register file engine: directed and random instruction
// stream, bit-exact prediction of every result beat. depends on hdl/mrf_pkg.sv and the engine top
`timescale 1ns / 1ps

module matrix_register_file_engine_tb;
	import mrf_pkg::*;

	typedef struct packed {
		logic [2:0]  pad;
		logic [31:0] value;
		logic [4:0]  ccnt;
		logic [4:0]  rcnt;
		logic [3:0]  col;
		logic [3:0]  row;
		logic [4:0]  rd;
		logic [4:0]  rb;
		logic [4:0]  ra;
		logic [3:0]  op;
	} instr_t;

	localparam int MAT     = DIM * DIM;
	localparam int WD_LIMIT = 20000;

	class mrf_scoreboard;
		word_t     mem [NUM_REGS*MAT];
		bit        written [NUM_REGS*MAT];
		int        wcount [NUM_REGS];
		logic [39:0] result_q [$];
		int        errors;

		function new();
			for (int i = 0; i < NUM_REGS*MAT; i++) begin
				mem[i] = '0;
				written[i] = 0;
			end
			for (int k = 0; k < NUM_REGS; k++) wcount[k] = 0;
			errors = 0;
		endfunction

		function int addr(int k, int r, int c);
			return k * MAT + r * DIM + c;
		endfunction

		function void put(int a, word_t v);
			mem[a] = v;
			if (!written[a]) begin
				written[a] = 1;
				wcount[a / MAT]++;
			end
		endfunction

		function word_t sat(longint v);
			if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
			if (v < -longint'(32'sh7FFFFFFF) - 1) return 32'sh80000000;
			return word_t'(v);
		endfunction

		// 64-bit product, arithmetic shift floors toward minus infinity
		function word_t qmul(word_t a, word_t b);
			longint p;
			p = longint'(a) * longint'(b);
			return sat(p >>> 16);
		endfunction

		function void swap_diag(int k);
			word_t t;
			for (int i = 0; i < DIM; i++)
				for (int j = i + 1; j < DIM; j++) begin
					t = mem[addr(k, j, i)];
					put(addr(k, j, i), mem[addr(k, i, j)]);
					put(addr(k, i, j), t);
				end
		endfunction

		function void note(instr_t x);
			word_t rv;
			int rc, cc;
			rv = '0;
			rc = (x.rcnt > DIM) ? DIM : x.rcnt;
			cc = (x.ccnt > DIM) ? DIM : x.ccnt;
			case (x.op)
				OP_LOAD:  put(addr(x.ra, x.row, x.col), x.value);
				OP_READ:  rv = mem[addr(x.ra, x.row, x.col)];
				OP_COLSCALE:
					for (int i = 0; i < cc; i++)
						for (int j = 0; j < rc; j++)
							put(addr(x.rd, j, i), qmul(mem[addr(x.ra, j, i)],
								mem[addr(x.rb, 0, i)]));
				OP_ROWSUM:
					for (int j = 0; j < rc; j++) begin
						put(addr(x.rd, j, 0), '0);
						for (int i = 0; i < cc; i++)
							put(addr(x.rd, j, 0), sat(longint'(mem[addr(x.rd, j, 0)])
								+ longint'(mem[addr(x.ra, j, i)])));
					end
				OP_ADD:
					for (int n = 0; n < MAT; n++)
						put(x.rd*MAT + n, sat(longint'(mem[x.ra*MAT + n])
							+ longint'(mem[x.rb*MAT + n])));
				OP_EMUL:
					for (int n = 0; n < MAT; n++)
						put(x.rd*MAT + n, qmul(mem[x.ra*MAT + n], mem[x.rb*MAT + n]));
				OP_RELU:
					for (int n = 0; n < MAT; n++)
						put(x.rd*MAT + n, mem[x.ra*MAT + n] < 0 ? word_t'(0) : mem[x.ra*MAT + n]);
				OP_TRANSPOSE: swap_diag(x.ra);
				OP_TCOPY: begin
					for (int n = 0; n < MAT; n++) put(x.rd*MAT + n, mem[x.ra*MAT + n]);
					swap_diag(x.rd);
				end
				default: ;
			endcase
			result_q.push_back({4'b0, x.op, rv});
		endfunction

		task report(string what, logic [39:0] got, logic [39:0] want);
			errors++;
			$display("%0t: %s got %h want %h", $time, what, got, want);
		endtask

		task check(logic [39:0] got);
			logic [39:0] want;
			if (result_q.size() == 0) begin
				report("unexpected result beat", got, 'x);
				return;
			end
			want = result_q.pop_front();
			if (got[31:0] !== want[31:0]) report("read_value", got, want);
			if (got[35:32] !== want[35:32]) report("op_echo", got, want);
			if (got[39:36] !== 4'b0) report("pad bits", got, want);
		endtask
	endclass

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata;
	logic            m_tvalid;
	logic            m_tready;
	logic [OUT_W-1:0] m_tdata;

	mrf_scoreboard sb;
	int  burst_left;
	bit  hold_req;
	int  idle_cycles;

	matrix_register_file_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// receiver: ready stretches, random stalls, and a long hold on request
	initial begin
		int mode_left, hold_left;
		bit stall_mode;
		bit hold_taken;
		m_tready = 1'b0;
		mode_left = 0;
		hold_left = 0;
		stall_mode = 0;
		hold_taken = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_left = 400;
				hold_taken = 1;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(10, 120);
				stall_mode = $urandom_range(0, 1);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= stall_mode ? ($urandom_range(0, 99) < 60) : 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task send(instr_t x);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		do @(posedge clk); while (!s_tready);
		sb.note(x);
	endtask

	function logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $urandom_range(0, 32'hFFFF) - 32'h8000;
		endcase
	endfunction

	function logic [4:0] full_reg();
		logic [4:0] r;
		do r = 5'($urandom_range(0, NUM_REGS - 1)); while (sb.wcount[r] != MAT);
		return r;
	endfunction

	function instr_t mk(int op, int ra, int rb, int rd, int row, int col, int rc, int cc,
		int v);
		instr_t x;
		x.pad   = 3'b0;
		x.value = 32'(v);
		x.ccnt  = 5'(cc);
		x.rcnt  = 5'(rc);
		x.col   = 4'(col);
		x.row   = 4'(row);
		x.rd    = 5'(rd);
		x.rb    = 5'(rb);
		x.ra    = 5'(ra);
		x.op    = 4'(op);
		return x;
	endfunction

	// random instruction; a read hits a written cell, every op but load and read sources fully written registers
	function instr_t random_instr();
		instr_t x;
		int k;
		x = {3'b0, 69'(0)};
		x.value = $urandom;
		x.ra = 5'($urandom); x.rb = 5'($urandom); x.rd = 5'($urandom);
		x.row = 4'($urandom); x.col = 4'($urandom);
		x.rcnt = 5'($urandom); x.ccnt = 5'($urandom);
		k = $urandom_range(0, 99);
		if (k < 35) begin
			x.op = OP_LOAD;
			x.value = pick_value();
		end else if (k < 60) begin
			x.op = OP_READ;
			if (!sb.written[sb.addr(x.ra, x.row, x.col)]) x.ra = full_reg();
		end else begin
			x.ra = full_reg();
			x.rb = full_reg();
			if (k < 66) x.op = OP_COLSCALE;
			else if (k < 72) x.op = OP_ROWSUM;
			else if (k < 78) x.op = OP_ADD;
			else if (k < 84) x.op = OP_EMUL;
			else if (k < 89) x.op = OP_RELU;
			else if (k < 93) x.op = OP_TRANSPOSE;
			else if (k < 97) x.op = OP_TCOPY;
			else x.op = 4'($urandom_range(9, 15));
			if ($urandom_range(0, 9) == 0) x.rd = x.ra;
		end
		return x;
	endfunction

	initial begin
		sb = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		hold_req = 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill two registers so every source read has data behind it
		for (int k = 0; k < 2; k++)
			for (int e = 0; e < MAT; e++)
				send(mk(OP_LOAD, k, $urandom, $urandom, e / DIM, e % DIM, $urandom,
					$urandom, pick_value()));

		// directed: extremes, every op, aliasing, clamped and zero counts
		send(mk(OP_LOAD, 2, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
		send(mk(OP_LOAD, 2, 0, 0, 0, 1, 0, 0, 32'h80000000));
		send(mk(OP_LOAD, 31, 31, 31, 15, 15, 31, 31, 32'hFFFFFFFF));
		send(mk(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0));
		send(mk(OP_READ, 2, 0, 0, 0, 1, 0, 0, 0));
		send(mk(OP_READ, 31, 0, 0, 15, 15, 0, 0, 32'hFFFFFFFF));
		send(mk(OP_COLSCALE, 0, 1, 3, 0, 0, 31, 31, 0));
		send(mk(OP_COLSCALE, 0, 1, 4, 0, 0, 0, 5, 0));
		send(mk(OP_COLSCALE, 1, 1, 1, 0, 0, 7, 16, 0));
		send(mk(OP_ROWSUM, 0, 0, 5, 0, 0, 16, 17, 0));
		send(mk(OP_ROWSUM, 0, 0, 0, 0, 0, 9, 0, 0));
		send(mk(OP_ROWSUM, 1, 0, 1, 0, 0, 16, 16, 0));
		send(mk(OP_ADD, 0, 1, 6, 0, 0, 0, 0, 0));
		send(mk(OP_ADD, 6, 6, 6, 0, 0, 0, 0, 0));
		send(mk(OP_EMUL, 0, 1, 7, 0, 0, 0, 0, 0));
		send(mk(OP_EMUL, 7, 7, 7, 0, 0, 0, 0, 0));
		send(mk(OP_RELU, 0, 0, 8, 0, 0, 0, 0, 0));
		send(mk(OP_TRANSPOSE, 1, 0, 0, 0, 0, 0, 0, 0));
		send(mk(OP_TCOPY, 0, 0, 9, 0, 0, 0, 0, 0));
		send(mk(OP_TCOPY, 9, 0, 9, 0, 0, 0, 0, 0));
		send(mk(9, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(15, 31, 31, 31, 15, 15, 31, 31, 32'hFFFFFFFF));
		send(mk(OP_READ, 6, 0, 0, 15, 0, 0, 0, 0));
		send(mk(OP_READ, 5, 0, 0, 3, 0, 0, 0, 0));

		for (int n = 0; n < 160; n++) begin
			if (n == 50) hold_req = 1;
			if (n == 100) begin
				s_tvalid <= 1'b0;
				burst_left = 0;
				while (sb.result_q.size() != 0) @(posedge clk);
			end
			send(random_instr());
		end
		s_tvalid <= 1'b0;

		while (sb.result_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.result_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
